/* hdl/ssc_pkg.sv */
// Shared types and helpers for the sphere pair contact pipeline.
// No dependencies; used by every other file of the block.
package ssc_pkg;

  localparam int unsigned IN_BITS   = 256;
  localparam int unsigned OUT_BITS  = 320;
  localparam int unsigned SQRT_STEPS = 33;  // one root bit per stage
  localparam int unsigned DIV_STEPS  = 31;  // one quotient bit per stage

  // Side data carried next to the square root stages.
  typedef struct packed {
    logic [2:0][31:0] p1;
    logic [2:0][31:0] p2;
    logic [2:0][32:0] dmag;
    logic [2:0]       dneg;
    logic [30:0]      r1;
    logic [30:0]      r2;
  } isq_side_t;

  // Side data carried next to the divider stages.
  typedef struct packed {
    logic [2:0][31:0] p1;
    logic [2:0][31:0] p2;
    logic [2:0]       dneg;
    logic [30:0]      r1;
    logic [30:0]      r2;
    logic [31:0]      depth;
    logic             contact;
    logic             dist_zero;
  } div_side_t;

  // Clamp a 34 bit signed value to the signed 32 bit range.
  function automatic logic [31:0] sat34(input logic signed [33:0] v);
    logic [31:0] res;
    if (v > 34'sh0_7FFF_FFFF) begin
      res = 32'h7FFF_FFFF;
    end else if (v < -34'sh0_8000_0000) begin
      res = 32'h8000_0000;
    end else begin
      res = v[31:0];
    end
    return res;
  endfunction

endpackage

/* hdl/ssc_isqrt.sv */
// Pipelined integer square root, one result bit per register stage.
// Depends on ssc_pkg for the side data type and the stage count.
module ssc_isqrt
  import ssc_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        en,
  input  logic        in_valid,
  input  logic [65:0] rad,
  input  isq_side_t   in_side,
  output logic        out_valid,
  output logic [32:0] root,
  output isq_side_t   out_side
);

  logic [35:0] rem_q  [SQRT_STEPS];
  logic [32:0] root_q [SQRT_STEPS];
  logic [65:0] rad_q  [SQRT_STEPS];
  isq_side_t   side_q [SQRT_STEPS];
  logic        vld_q  [SQRT_STEPS];

  for (genvar k = 0; k < SQRT_STEPS; k++) begin : g_step
    logic [35:0] rem_in;
    logic [32:0] root_in;
    logic [65:0] rad_in;
    isq_side_t   side_in;
    logic        vld_in;
    logic [35:0] shifted;
    logic [35:0] trial;
    logic        take;

    if (k == 0) begin : g_first
      assign rem_in  = '0;
      assign root_in = '0;
      assign rad_in  = rad;
      assign side_in = in_side;
      assign vld_in  = in_valid;
    end else begin : g_rest
      assign rem_in  = rem_q[k-1];
      assign root_in = root_q[k-1];
      assign rad_in  = rad_q[k-1];
      assign side_in = side_q[k-1];
      assign vld_in  = vld_q[k-1];
    end

    // Bring down the next two radicand bits and try root*4+1.
    assign shifted = {rem_in[33:0], rad_in[65:64]};
    assign trial   = {1'b0, root_in, 2'b01};
    assign take    = shifted >= trial;

    always_ff @(posedge clk) begin
      if (rst) begin
        vld_q[k] <= 1'b0;
      end else if (en) begin
        vld_q[k] <= vld_in;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_q[k]  <= take ? shifted - trial : shifted;
        root_q[k] <= {root_in[31:0], take};
        rad_q[k]  <= {rad_in[63:0], 2'b00};
        side_q[k] <= side_in;
      end
    end
  end

  assign out_valid = vld_q[SQRT_STEPS-1];
  assign root      = root_q[SQRT_STEPS-1];
  assign out_side  = side_q[SQRT_STEPS-1];

endmodule

/* hdl/ssc_div.sv */
// Three lane pipelined restoring divider for the unit normal, one quotient
// bit per stage. Depends on ssc_pkg for the side data type and stage count.
module ssc_div
  import ssc_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             en,
  input  logic             in_valid,
  input  logic [2:0][32:0] num,
  input  logic [32:0]      divisor,
  input  div_side_t        in_side,
  output logic             out_valid,
  output logic [2:0][30:0] quot,
  output div_side_t        out_side
);

  logic [2:0][33:0] rem_q  [DIV_STEPS];
  logic [2:0][30:0] quo_q  [DIV_STEPS];
  logic [32:0]      dvs_q  [DIV_STEPS];
  div_side_t        side_q [DIV_STEPS];
  logic             vld_q  [DIV_STEPS];

  for (genvar k = 0; k < DIV_STEPS; k++) begin : g_step
    logic [2:0][33:0] cand;
    logic [2:0][30:0] quo_in;
    logic [2:0]       take;
    logic [32:0]      dvs_in;
    div_side_t        side_in;
    logic             vld_in;

    // The numerator never exceeds the distance, so the first quotient bit
    // comes from a plain compare and later bits from the shifted remainder.
    if (k == 0) begin : g_first
      for (genvar l = 0; l < 3; l++) begin : g_lane
        assign cand[l] = {1'b0, num[l]};
      end
      assign quo_in  = '0;
      assign dvs_in  = divisor;
      assign side_in = in_side;
      assign vld_in  = in_valid;
    end else begin : g_rest
      for (genvar l = 0; l < 3; l++) begin : g_lane
        assign cand[l] = {rem_q[k-1][l][32:0], 1'b0};
      end
      assign quo_in  = quo_q[k-1];
      assign dvs_in  = dvs_q[k-1];
      assign side_in = side_q[k-1];
      assign vld_in  = vld_q[k-1];
    end

    for (genvar l = 0; l < 3; l++) begin : g_cmp
      assign take[l] = cand[l] >= {1'b0, dvs_in};
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vld_q[k] <= 1'b0;
      end else if (en) begin
        vld_q[k] <= vld_in;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        for (int l = 0; l < 3; l++) begin
          rem_q[k][l] <= take[l] ? cand[l] - {1'b0, dvs_in} : cand[l];
          quo_q[k][l] <= {quo_in[l][29:0], take[l]};
        end
        dvs_q[k]  <= dvs_in;
        side_q[k] <= side_in;
      end
    end
  end

  assign out_valid = vld_q[DIV_STEPS-1];
  assign quot      = quo_q[DIV_STEPS-1];
  assign out_side  = side_q[DIV_STEPS-1];

endmodule

/* hdl/sphere_sphere_contact_unit.sv */
// Sphere pair contact test: three front stages, square root and divider
// pipelines, then multiply and output stages. Depends on ssc_pkg,
// ssc_isqrt and ssc_div.
//
// Usage: each request on the s_ channel carries two sphere centres and two
// radii; each request on the m_ channel carries the contact result of one
// input request, in the same order. The pipeline accepts one request per
// clock cycle and returns one result per cycle once filled, while the
// output is not stalled. From acceptance to m_tvalid a request passes
// three stages for the centre difference, squares and sum, 33 square root
// stages (one root bit each), 31 divider stages (one normal bit each), one
// multiply stage and the output register.
// The whole pipeline advances together: when m_tvalid is high and
// m_tready is low, every stage holds and s_tready falls in the same cycle,
// so no request is lost or repeated. Empty slots travel as bubbles.
// A synchronous reset clears every valid bit; the payload registers keep
// whatever they held and are ignored until valid data reaches them.
// Coincident centres give a zero normal; without contact all surface
// point fields are zero.
module sphere_sphere_contact_unit
  import ssc_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                s_tvalid,
  output logic                s_tready,
  // first_x, first_y, first_z, second_x, second_y, second_z,
  // first_radius, second_radius, then two zero bits
  input  logic [IN_BITS-1:0]  s_tdata,
  output logic                m_tvalid,
  input  logic                m_tready,
  // depth, normal_x, normal_y, normal_z, point_a_x, point_a_y, point_a_z,
  // point_b_x, point_b_y, point_b_z
  output logic [OUT_BITS-1:0] m_tdata,
  // contact_found
  output logic                m_tuser
);

  logic en;

  // The pipeline moves whenever the output register is empty or drained.
  assign en       = !m_tvalid || m_tready;
  assign s_tready = en;

  // Stage 1: centre difference.
  logic                    v1;
  logic [2:0][31:0]        p1_1, p2_1;
  logic [2:0][32:0]        d1;
  logic [30:0]             r1_1, r2_1;

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        p1_1[i] <= s_tdata[32*i +: 32];
        p2_1[i] <= s_tdata[96 + 32*i +: 32];
        d1[i]   <= {s_tdata[96 + 32*i + 31], s_tdata[96 + 32*i +: 32]}
                   - {s_tdata[32*i + 31], s_tdata[32*i +: 32]};
      end
      r1_1 <= s_tdata[222:192];
      r2_1 <= s_tdata[253:223];
    end
  end

  // Stage 2: magnitudes and their squares.
  logic             v2;
  logic [2:0][32:0] mag1;
  logic [2:0][65:0] sq2;
  isq_side_t        side2;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      mag1[i] = d1[i][32] ? 33'(-d1[i]) : d1[i];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        sq2[i]        <= {33'b0, mag1[i]} * {33'b0, mag1[i]};
        side2.dneg[i] <= d1[i][32];
      end
      side2.p1   <= p1_1;
      side2.p2   <= p2_1;
      side2.dmag <= mag1;
      side2.r1   <= r1_1;
      side2.r2   <= r2_1;
    end
  end

  // Stage 3: sum of squares, at most three times 2^64.
  logic        v3;
  logic [65:0] sum3;
  isq_side_t   side3;

  always_ff @(posedge clk) begin
    if (en) begin
      sum3  <= sq2[0] + sq2[1] + sq2[2];
      side3 <= side2;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else if (en) begin
      v1 <= s_tvalid;
      v2 <= v1;
      v3 <= v2;
    end
  end

  // Centre distance.
  logic        iv;
  logic [32:0] root;
  isq_side_t   iside;

  ssc_isqrt u_isqrt (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (v3),
    .rad       (sum3),
    .in_side   (side3),
    .out_valid (iv),
    .root      (root),
    .out_side  (iside)
  );

  // Depth and contact decision, formed in front of the divider.
  logic signed [34:0] depth_full;
  div_side_t          dside_in;

  assign depth_full = $signed({4'b0, iside.r1}) + $signed({4'b0, iside.r2})
                      - $signed({2'b0, root});

  always_comb begin
    dside_in.p1        = iside.p1;
    dside_in.p2        = iside.p2;
    dside_in.dneg      = iside.dneg;
    dside_in.r1        = iside.r1;
    dside_in.r2        = iside.r2;
    dside_in.contact   = !depth_full[34] && (depth_full != '0);
    dside_in.dist_zero = (root == '0);
    // The depth fits in 34 bits, so the top bit only repeats the sign.
    dside_in.depth     = sat34(depth_full[33:0]);
  end

  // Unit normal magnitudes.
  logic             dv;
  logic [2:0][30:0] quot;
  div_side_t        dside;

  ssc_div u_div (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (iv),
    .num       (iside.dmag),
    .divisor   (root),
    .in_side   (dside_in),
    .out_valid (dv),
    .quot      (quot),
    .out_side  (dside)
  );

  // Multiply stage: normal magnitude times each radius.
  logic             vm;
  logic [2:0][30:0] nm;
  logic [2:0][31:0] nrm_m;
  logic [2:0][61:0] prod_a, prod_b;
  div_side_t        mside;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      nm[i] = dside.dist_zero ? '0 : quot[i];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        nrm_m[i]  <= dside.dneg[i] ? 32'(-{1'b0, nm[i]}) : {1'b0, nm[i]};
        prod_a[i] <= {31'b0, nm[i]} * {31'b0, dside.r1};
        prod_b[i] <= {31'b0, nm[i]} * {31'b0, dside.r2};
      end
      mside <= dside;
    end
  end

  // Output stage: offsets truncated toward zero, then saturated points.
  logic [2:0][31:0]        pa, pb;
  logic signed [2:0][33:0] off_a, off_b;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      off_a[i] = $signed({3'b0, prod_a[i][60:30]});
      off_b[i] = $signed({3'b0, prod_b[i][60:30]});
      if (mside.dneg[i]) begin
        off_a[i] = -off_a[i];
        off_b[i] = -off_b[i];
      end
      pa[i] = sat34($signed({{2{mside.p1[i][31]}}, mside.p1[i]}) + off_a[i]);
      pb[i] = sat34($signed({{2{mside.p2[i][31]}}, mside.p2[i]}) - off_b[i]);
      if (!mside.contact) begin
        pa[i] = '0;
        pb[i] = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      m_tdata <= {pb[2], pb[1], pb[0], pa[2], pa[1], pa[0],
                  nrm_m[2], nrm_m[1], nrm_m[0], mside.depth};
      m_tuser <= mside.contact;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vm       <= 1'b0;
      m_tvalid <= 1'b0;
    end else if (en) begin
      vm       <= dv;
      m_tvalid <= vm;
    end
  end

endmodule

/* hdl/ssc_checker.sv */
// Port level checks for the sphere pair contact pipeline, bound to the top.
// Depends on ssc_pkg for the bus widths.
module ssc_checker
  import ssc_pkg::*;
(
  input logic                clk,
  input logic                rst,
  input logic                s_tvalid,
  input logic                s_tready,
  input logic [IN_BITS-1:0]  s_tdata,
  input logic                m_tvalid,
  input logic                m_tready,
  input logic [OUT_BITS-1:0] m_tdata,
  input logic                m_tuser
);

  // A held result keeps its payload.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("result changed while stalled");

  // The input side stalls exactly when a result is waiting.
  a_ready: assert property (@(posedge clk) disable iff (rst)
    s_tready == (!m_tvalid || m_tready))
    else $error("input ready does not follow output stall");

  // No result appears right after reset.
  a_reset: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("result valid after reset");

  // Without contact the surface points are all zero.
  a_nopts: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tuser |-> m_tdata[319:128] == '0)
    else $error("surface points set without contact");

  // A contact always has a strictly positive depth.
  a_depth: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser |-> !m_tdata[31] && m_tdata[31:0] != '0)
    else $error("contact with non positive depth");

endmodule

bind sphere_sphere_contact_unit ssc_checker u_ssc_checker (.*);
